// File: hw/rtl/cpf_pkg.sv
// cpf_pkg: shared widths, codes, reset values and transaction types of the
// cutoff pair finder. No dependencies.
`default_nettype none

package cpf_pkg;

   localparam int POS_W      = 20;
   localparam int IDX_W      = 6;
   localparam int CNT_W      = 7;
   localparam int CUT_W      = 44;
   localparam int PAIR_W     = 9;
   localparam int LIM_W      = 11;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = CUT_W;

   localparam int DEFAULT_MAX_ATOMS = 64;
   localparam int QUEUE_DEPTH       = 2;
   localparam int LIMIT_FACTOR      = 10;

   localparam logic [PAIR_W-1:0] COUNT_MAX = '1;

   localparam logic [CNT_W-1:0] ATOM_COUNT_RESET = 7'd64;
   localparam logic [POS_W-1:0] HALF_BOX_RESET   = 20'd1048575;
   localparam logic [CUT_W-1:0] CUTOFF_RESET     = 44'd655360;

   typedef enum logic {
      REQ_LOAD = 1'b0,
      REQ_SCAN = 1'b1
   } req_code_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ATOM_COUNT   = 3'd0,
      CSR_HALF_BOX_X   = 3'd1,
      CSR_HALF_BOX_Y   = 3'd2,
      CSR_HALF_BOX_Z   = 3'd3,
      CSR_CUTOFF_LIMIT = 3'd4
   } csr_reg_type;

   typedef struct packed {
      logic [CNT_W-1:0] atom_count;
      logic [POS_W-1:0] half_box_x;
      logic [POS_W-1:0] half_box_y;
      logic [POS_W-1:0] half_box_z;
      logic [CUT_W-1:0] cutoff_limit;
   } cfg_type;

   typedef struct packed {
      logic                    is_scan;
      logic                    store_en;
      logic [IDX_W-1:0]        index;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_stat_type;

endpackage

`default_nettype wire

// File: hw/rtl/cpf_ram.sv
// cpf_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module cpf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/cpf_cmd_queue.sv
// cpf_cmd_queue: front end; accepts request transactions, classifies them and
// queues them for the scan engine. Depends on cpf_pkg.
`default_nettype none

module cpf_cmd_queue #(
   parameter int MAX_ATOMS = cpf_pkg::DEFAULT_MAX_ATOMS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic                            req_type,
   input  wire logic [cpf_pkg::IDX_W-1:0]       req_atom_index,
   input  wire logic signed [cpf_pkg::POS_W-1:0] req_pos_x,
   input  wire logic signed [cpf_pkg::POS_W-1:0] req_pos_y,
   input  wire logic signed [cpf_pkg::POS_W-1:0] req_pos_z,
   output logic                                 cmd_valid,
   output cpf_pkg::cmd_type                     cmd,
   input  wire logic                            cmd_pop,
   output cpf_pkg::queue_stat_type              stat
);

   localparam int DEPTH = cpf_pkg::QUEUE_DEPTH;
   localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);

   cpf_pkg::cmd_type entry_ff [DEPTH];
   cpf_pkg::cmd_type new_cmd;
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             push;
   logic             pop;

   assign req_ready = (count_ff != CW'(DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd       = entry_ff[rd_ptr_ff];
   assign push      = req_valid & req_ready;
   assign pop       = cmd_pop & cmd_valid;

   assign stat.empty = (count_ff == '0);
   assign stat.full  = ~req_ready;

   always_comb begin
      new_cmd.is_scan  = (req_type == cpf_pkg::REQ_SCAN);
      new_cmd.store_en = (req_type == cpf_pkg::REQ_LOAD) && (int'(req_atom_index) < MAX_ATOMS);
      new_cmd.index    = req_atom_index;
      new_cmd.pos_x    = req_pos_x;
      new_cmd.pos_y    = req_pos_y;
      new_cmd.pos_z    = req_pos_z;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      priority if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/cpf_scan_engine.sv
// cpf_scan_engine: back end; writes positions, streams a row scan through a
// read, axis test, square and cutoff pipeline, and drives the response register.
// Depends on cpf_pkg and cpf_ram.
`default_nettype none

module cpf_scan_engine #(
   parameter int MAX_ATOMS = cpf_pkg::DEFAULT_MAX_ATOMS
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire cpf_pkg::cfg_type          cfg,
   input  wire logic                      cmd_valid,
   input  wire cpf_pkg::cmd_type          cmd,
   output logic                           cmd_pop,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic                           rsp_pair_valid,
   output logic [cpf_pkg::IDX_W-1:0]      rsp_first_atom,
   output logic [cpf_pkg::IDX_W-1:0]      rsp_second_atom,
   output logic                           rsp_last_of_run
);

   localparam int AW     = $clog2(MAX_ATOMS);
   localparam int POS_W  = cpf_pkg::POS_W;
   localparam int IDX_W  = cpf_pkg::IDX_W;
   localparam int CNT_W  = cpf_pkg::CNT_W;
   localparam int PAIR_W = cpf_pkg::PAIR_W;
   localparam int LIM_W  = cpf_pkg::LIM_W;
   localparam int SQ_W   = 2 * POS_W;
   localparam int SUM_W  = SQ_W + 2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROW,
      ST_ROW_CAP,
      ST_SCAN,
      ST_DRAIN
   } state_type;

   function automatic logic [POS_W-1:0] abs_diff(input logic [POS_W-1:0] a,
                                                 input logic [POS_W-1:0] b);
      logic [POS_W:0] d;
      d = {a[POS_W-1], a} - {b[POS_W-1], b};
      abs_diff = d[POS_W] ? POS_W'(-d) : d[POS_W-1:0];
   endfunction

   state_type         state_ff;
   logic [IDX_W-1:0]  row_ff;
   logic [CNT_W-1:0]  n_ff;
   logic [CNT_W-1:0]  j_ff;
   logic [POS_W-1:0]  row_x_ff, row_y_ff, row_z_ff;

   logic              v1_ff;
   logic [CNT_W-1:0]  j1_ff;
   logic              v2_ff, ok2_ff;
   logic [CNT_W-1:0]  j2_ff;
   logic [POS_W-1:0]  mx2_ff, my2_ff, mz2_ff;
   logic              v3_ff, ok3_ff;
   logic [CNT_W-1:0]  j3_ff;
   logic [SQ_W-1:0]   sx3_ff, sy3_ff, sz3_ff;

   logic [PAIR_W-1:0] pair_count_ff;
   logic              pend_valid_ff;
   logic [CNT_W-1:0]  pend_j_ff;

   logic              out_valid_ff, out_pair_ff, out_last_ff;
   logic [IDX_W-1:0]  out_first_ff, out_second_ff;

   logic              advance;
   logic [CNT_W-1:0]  n_eff;
   logic              issue;
   logic              ram_wr_en, ram_rd_en;
   logic [AW-1:0]     ram_rd_addr;
   logic [3*POS_W-1:0] ram_rd_data;
   logic [POS_W-1:0]  rd_x, rd_y, rd_z;
   logic [POS_W-1:0]  mx1, my1, mz1;
   logic              ok1;
   logic [SUM_W-1:0]  sum3;
   logic              count_ok;
   logic              hit3;
   logic              pipe_empty;
   logic              load_push, pair_push, final_push;

   assign advance    = ~(out_valid_ff & ~rsp_ready);
   assign n_eff      = (int'(cfg.atom_count) > MAX_ATOMS) ? CNT_W'(MAX_ATOMS) : cfg.atom_count;
   assign pipe_empty = ~v1_ff & ~v2_ff & ~v3_ff;
   assign issue      = (state_ff == ST_SCAN) && (j_ff < n_ff);
   assign cmd_pop    = advance && (state_ff == ST_IDLE) && cmd_valid;

   assign ram_wr_en   = cmd_pop && !cmd.is_scan && cmd.store_en;
   assign ram_rd_en   = advance && ((state_ff == ST_ROW) || issue);
   assign ram_rd_addr = (state_ff == ST_ROW) ? AW'(row_ff) : AW'(j_ff);

   cpf_ram #(
      .WIDTH (3 * POS_W),
      .DEPTH (MAX_ATOMS)
   ) u_pos_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (AW'(cmd.index)),
      .wr_data ({cmd.pos_x, cmd.pos_y, cmd.pos_z}),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_x = ram_rd_data[3*POS_W-1 -: POS_W];
   assign rd_y = ram_rd_data[2*POS_W-1 -: POS_W];
   assign rd_z = ram_rd_data[POS_W-1:0];

   assign mx1 = abs_diff(row_x_ff, rd_x);
   assign my1 = abs_diff(row_y_ff, rd_y);
   assign mz1 = abs_diff(row_z_ff, rd_z);
   assign ok1 = (mx1 <= cfg.half_box_x) && (my1 <= cfg.half_box_y) && (mz1 <= cfg.half_box_z);

   assign sum3     = SUM_W'(sx3_ff) + SUM_W'(sy3_ff) + SUM_W'(sz3_ff);
   assign count_ok = {1'b0, pair_count_ff, 1'b0}
                     <= (LIM_W'(n_ff) * LIM_W'(cpf_pkg::LIMIT_FACTOR));
   assign hit3     = v3_ff && ok3_ff && count_ok
                     && ({{(cpf_pkg::CUT_W - SUM_W){1'b0}}, sum3} <= cfg.cutoff_limit);

   assign load_push  = cmd_pop && !cmd.is_scan;
   assign pair_push  = hit3 && pend_valid_ff;
   assign final_push = (state_ff == ST_DRAIN) && pipe_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
         pair_count_ff <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else if (advance) begin
         v1_ff <= issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;

         unique case (state_ff)
            ST_IDLE: begin
               if (cmd_valid && cmd.is_scan) begin
                  pend_valid_ff <= 1'b0;
                  if (cmd.index == '0) begin
                     pair_count_ff <= '0;
                  end
                  state_ff <= (CNT_W'(cmd.index) < n_eff) ? ST_ROW : ST_DRAIN;
               end
            end
            ST_ROW: begin
               state_ff <= ST_ROW_CAP;
            end
            ST_ROW_CAP: begin
               state_ff <= ST_SCAN;
            end
            ST_SCAN: begin
               if (!issue) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               if (pipe_empty) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase

         if (hit3) begin
            pend_valid_ff <= 1'b1;
            if (pair_count_ff != cpf_pkg::COUNT_MAX) begin
               pair_count_ff <= pair_count_ff + PAIR_W'(1);
            end
         end

         priority if (load_push || pair_push || final_push) begin
            out_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         if (cmd_pop && cmd.is_scan) begin
            row_ff <= cmd.index;
            n_ff   <= n_eff;
            j_ff   <= CNT_W'(cmd.index) + CNT_W'(1);
         end
         if (issue) begin
            j_ff <= j_ff + CNT_W'(1);
         end
         if (state_ff == ST_ROW_CAP) begin
            row_x_ff <= rd_x;
            row_y_ff <= rd_y;
            row_z_ff <= rd_z;
         end

         j1_ff  <= j_ff;
         j2_ff  <= j1_ff;
         ok2_ff <= ok1;
         mx2_ff <= mx1;
         my2_ff <= my1;
         mz2_ff <= mz1;
         j3_ff  <= j2_ff;
         ok3_ff <= ok2_ff;
         sx3_ff <= mx2_ff * mx2_ff;
         sy3_ff <= my2_ff * my2_ff;
         sz3_ff <= mz2_ff * mz2_ff;

         if (hit3) begin
            pend_j_ff <= j3_ff;
         end

         priority if (load_push) begin
            out_pair_ff   <= 1'b0;
            out_first_ff  <= cmd.index;
            out_second_ff <= '0;
            out_last_ff   <= 1'b1;
         end else if (pair_push) begin
            out_pair_ff   <= 1'b1;
            out_first_ff  <= row_ff;
            out_second_ff <= pend_j_ff[IDX_W-1:0];
            out_last_ff   <= 1'b0;
         end else if (final_push) begin
            out_pair_ff   <= pend_valid_ff;
            out_first_ff  <= row_ff;
            out_second_ff <= pend_valid_ff ? pend_j_ff[IDX_W-1:0] : '0;
            out_last_ff   <= 1'b1;
         end else begin
            out_pair_ff   <= out_pair_ff;
         end
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_pair_valid  = out_pair_ff;
   assign rsp_first_atom  = out_first_ff;
   assign rsp_second_atom = out_second_ff;
   assign rsp_last_of_run = out_last_ff;

endmodule

`default_nettype wire

// File: hw/rtl/cutoff_pair_finder.sv
// cutoff_pair_finder: top level; configuration registers, command queue and
// scan engine. Depends on cpf_pkg, cpf_cmd_queue and cpf_scan_engine.
//
// A load transaction writes one atom position and yields one acknowledgement in
// the cycle after it leaves the two-entry command queue. A scan of row r reads
// the row position, then one stored position per cycle while the engine is not
// frozen, from the single read port of the position RAM for each j in
// r+1 .. n-1, where n is atom_count limited to MAX_ATOMS; that read port sets
// the rate. Each scan holds back its latest pair so the final result can carry
// last_of_run; a scan with no pair gives one empty acknowledgement.
// The engine freezes while the response register holds an untaken result, and
// the queue keeps accepting requests until it is full. No clearing pass.
`default_nettype none

module cutoff_pair_finder #(
   parameter int MAX_ATOMS = cpf_pkg::DEFAULT_MAX_ATOMS
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic                             req_type,
   input  wire logic [cpf_pkg::IDX_W-1:0]        req_atom_index,
   input  wire logic signed [cpf_pkg::POS_W-1:0] req_pos_x,
   input  wire logic signed [cpf_pkg::POS_W-1:0] req_pos_y,
   input  wire logic signed [cpf_pkg::POS_W-1:0] req_pos_z,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic                                  rsp_pair_valid,
   output logic [cpf_pkg::IDX_W-1:0]             rsp_first_atom,
   output logic [cpf_pkg::IDX_W-1:0]             rsp_second_atom,
   output logic                                  rsp_last_of_run,
   input  wire logic                             csr_we,
   input  wire logic [cpf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [cpf_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   cpf_pkg::cfg_type        cfg_ff;
   cpf_pkg::cmd_type        cmd;
   cpf_pkg::queue_stat_type queue_stat;
   logic                    cmd_valid;
   logic                    cmd_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.atom_count   <= cpf_pkg::ATOM_COUNT_RESET;
         cfg_ff.half_box_x   <= cpf_pkg::HALF_BOX_RESET;
         cfg_ff.half_box_y   <= cpf_pkg::HALF_BOX_RESET;
         cfg_ff.half_box_z   <= cpf_pkg::HALF_BOX_RESET;
         cfg_ff.cutoff_limit <= cpf_pkg::CUTOFF_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            cpf_pkg::CSR_ATOM_COUNT:   cfg_ff.atom_count   <= csr_wdata[cpf_pkg::CNT_W-1:0];
            cpf_pkg::CSR_HALF_BOX_X:   cfg_ff.half_box_x   <= csr_wdata[cpf_pkg::POS_W-1:0];
            cpf_pkg::CSR_HALF_BOX_Y:   cfg_ff.half_box_y   <= csr_wdata[cpf_pkg::POS_W-1:0];
            cpf_pkg::CSR_HALF_BOX_Z:   cfg_ff.half_box_z   <= csr_wdata[cpf_pkg::POS_W-1:0];
            cpf_pkg::CSR_CUTOFF_LIMIT: cfg_ff.cutoff_limit <= csr_wdata[cpf_pkg::CUT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   cpf_cmd_queue #(
      .MAX_ATOMS (MAX_ATOMS)
   ) u_cmd_queue (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_atom_index (req_atom_index),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_pos_z      (req_pos_z),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd),
      .cmd_pop        (cmd_pop),
      .stat           (queue_stat)
   );

   cpf_scan_engine #(
      .MAX_ATOMS (MAX_ATOMS)
   ) u_scan_engine (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd),
      .cmd_pop         (cmd_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pair_valid  (rsp_pair_valid),
      .rsp_first_atom  (rsp_first_atom),
      .rsp_second_atom (rsp_second_atom),
      .rsp_last_of_run (rsp_last_of_run)
   );

`ifndef ASSERT_OFF
   a_ack_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_pair_valid |-> rsp_last_of_run)
      else $error("empty acknowledgement without last_of_run");

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pair_valid |-> (MAX_ATOMS > 64) || (rsp_second_atom > rsp_first_atom))
      else $error("pair indexes out of order");

   a_queue_filled: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !queue_stat.empty)
      else $error("accepted transaction missing from command queue");
`endif

endmodule

`default_nettype wire

// File: tb/cpf_scoreboard_pkg.sv
// cpf_scoreboard_pkg: pair_ledger, which predicts the acknowledgements and neighbor
// pairs of the cutoff pair finder and matches them against DUT responses.
// Depends on cpf_pkg for widths, codes and the register layout.
`timescale 1ns / 1ps

package cpf_scoreboard_pkg;
   import cpf_pkg::*;

   typedef struct packed {
      logic             pair_valid;
      logic [IDX_W-1:0] first_atom;
      logic [IDX_W-1:0] second_atom;
      logic             last_of_run;
   } pair_result_type;

   class pair_ledger;
      cfg_type                 settings;
      logic signed [POS_W-1:0] pos_x [DEFAULT_MAX_ATOMS];
      logic signed [POS_W-1:0] pos_y [DEFAULT_MAX_ATOMS];
      logic signed [POS_W-1:0] pos_z [DEFAULT_MAX_ATOMS];
      logic [PAIR_W-1:0]       pair_total;
      pair_result_type         pairs_due [$];
      int unsigned             mismatch_count;
      int unsigned             results_seen;
      int unsigned             pairs_seen;

      function new();
         settings.atom_count   = ATOM_COUNT_RESET;
         settings.half_box_x   = HALF_BOX_RESET;
         settings.half_box_y   = HALF_BOX_RESET;
         settings.half_box_z   = HALF_BOX_RESET;
         settings.cutoff_limit = CUTOFF_RESET;
         pair_total     = '0;
         mismatch_count = 0;
         results_seen   = 0;
         pairs_seen     = 0;
      endfunction

      function void write_reg(csr_reg_type which, logic [CSR_DATA_W-1:0] value);
         case (which)
            CSR_ATOM_COUNT:   settings.atom_count   = value[CNT_W-1:0];
            CSR_HALF_BOX_X:   settings.half_box_x   = value[POS_W-1:0];
            CSR_HALF_BOX_Y:   settings.half_box_y   = value[POS_W-1:0];
            CSR_HALF_BOX_Z:   settings.half_box_z   = value[POS_W-1:0];
            CSR_CUTOFF_LIMIT: settings.cutoff_limit = value[CUT_W-1:0];
            default: ;
         endcase
      endfunction

      function int unsigned pending();
         return pairs_due.size();
      endfunction

      function bit axis_within(logic signed [POS_W-1:0] a, logic signed [POS_W-1:0] b,
                               logic [POS_W-1:0] half, output longint sq);
         longint gap;
         gap = longint'(a) - longint'(b);
         if (gap < 0)
            gap = -gap;
         sq = gap * gap;
         return gap <= longint'({1'b0, half});
      endfunction

      function void take_request(req_code_type kind, logic [IDX_W-1:0] idx,
                                 logic signed [POS_W-1:0] px, logic signed [POS_W-1:0] py,
                                 logic signed [POS_W-1:0] pz);
         int              n;
         int              j;
         longint          sx;
         longint          sy;
         longint          sz;
         bit              holding;
         pair_result_type held;
         n = (settings.atom_count > DEFAULT_MAX_ATOMS) ? DEFAULT_MAX_ATOMS
                                                       : int'(settings.atom_count);
         holding = 1'b0;
         held = '0;
         held.first_atom = idx;
         if (kind == REQ_LOAD) begin
            pos_x[idx] = px;
            pos_y[idx] = py;
            pos_z[idx] = pz;
         end else begin
            if (idx == 0)
               pair_total = '0;
            for (j = int'(idx) + 1; j < n; j++) begin
               if (!axis_within(pos_x[idx], pos_x[j], settings.half_box_x, sx)) continue;
               if (!axis_within(pos_y[idx], pos_y[j], settings.half_box_y, sy)) continue;
               if (!axis_within(pos_z[idx], pos_z[j], settings.half_box_z, sz)) continue;
               if (sx + sy + sz > longint'({1'b0, settings.cutoff_limit})) continue;
               if (2 * int'(pair_total) > LIMIT_FACTOR * n) continue;
               if (pair_total != COUNT_MAX)
                  pair_total++;
               if (holding)
                  pairs_due.push_back(held);
               held.pair_valid  = 1'b1;
               held.second_atom = IDX_W'(j);
               holding = 1'b1;
            end
         end
         held.last_of_run = 1'b1;
         pairs_due.push_back(held);
      endfunction

      function void report(string what, pair_result_type want, pair_result_type got);
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("[%0t] %s: expected valid=%0b first=%0d second=%0d last=%0b, got valid=%0b first=%0d second=%0d last=%0b",
                     $time, what, want.pair_valid, want.first_atom, want.second_atom,
                     want.last_of_run, got.pair_valid, got.first_atom, got.second_atom,
                     got.last_of_run);
      endfunction

      function void match_result(pair_result_type got);
         pair_result_type want;
         results_seen++;
         if (pairs_due.size() == 0) begin
            report("unexpected response", '0, got);
            return;
         end
         want = pairs_due.pop_front();
         if (got.pair_valid !== want.pair_valid || got.first_atom !== want.first_atom ||
             got.second_atom !== want.second_atom || got.last_of_run !== want.last_of_run)
            report("response mismatch", want, got);
         else if (want.pair_valid)
            pairs_seen++;
      endfunction
   endclass

endpackage

// File: tb/tb_cutoff_pair_finder.sv
// tb_cutoff_pair_finder: drives loads, row scans and register settings into the
// cutoff pair finder with random idling on both channels and checks every response.
// Depends on cpf_pkg, cpf_scoreboard_pkg and cutoff_pair_finder.
`timescale 1ns / 1ps

module tb_cutoff_pair_finder;
   import cpf_pkg::*;
   import cpf_scoreboard_pkg::*;

   localparam logic [CSR_IDX_W-1:0]    CSR_UNUSED   = 3'd7;
   localparam logic signed [POS_W-1:0] POS_MIN      = 20'sh80000;
   localparam logic signed [POS_W-1:0] POS_MAX      = 20'sh7FFFF;
   localparam logic [POS_W-1:0]        HALF_MAX     = '1;
   localparam logic [CUT_W-1:0]        CUT_MAX      = '1;
   localparam int                      ATOM_SLOTS   = DEFAULT_MAX_ATOMS;
   localparam int                      RANDOM_ITEMS = 200;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_ready;
   logic                        req_type;
   logic [IDX_W-1:0]            req_atom_index;
   logic signed [POS_W-1:0]     req_pos_x;
   logic signed [POS_W-1:0]     req_pos_y;
   logic signed [POS_W-1:0]     req_pos_z;
   logic                        rsp_valid;
   logic                        rsp_ready;
   logic                        rsp_pair_valid;
   logic [IDX_W-1:0]            rsp_first_atom;
   logic [IDX_W-1:0]            rsp_second_atom;
   logic                        rsp_last_of_run;
   logic                        csr_we;
   logic [CSR_IDX_W-1:0]        csr_index;
   logic [CSR_DATA_W-1:0]       csr_wdata;

   pair_ledger                  ledger;
   logic signed [POS_W-1:0]     gx [ATOM_SLOTS];
   logic signed [POS_W-1:0]     gy [ATOM_SLOTS];
   logic signed [POS_W-1:0]     gz [ATOM_SLOTS];
   bit                          loaded [ATOM_SLOTS];
   bit                          quiet;
   int                          active_n;
   int                          item_total;
   int                          setting_total;

   cutoff_pair_finder DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_atom_index  (req_atom_index),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_pos_z       (req_pos_z),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pair_valid  (rsp_pair_valid),
      .rsp_first_atom  (rsp_first_atom),
      .rsp_second_atom (rsp_second_atom),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #25_000_000;
      $display("Some tests failed");
      $finish;
   end

   always @(posedge clock) begin
      pair_result_type seen;
      if (!reset) begin
         if (req_valid && req_ready)
            ledger.take_request(req_code_type'(req_type), req_atom_index,
                                req_pos_x, req_pos_y, req_pos_z);
         if (rsp_valid && rsp_ready) begin
            seen = {rsp_pair_valid, rsp_first_atom, rsp_second_atom, rsp_last_of_run};
            ledger.match_result(seen);
         end
      end
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (quiet)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [POS_W-1:0] rand_coord();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return POS_W'(int'($urandom_range(0, 2047)) - 1024);
      if (r < 85)
         return POS_W'($urandom());
      case ($urandom_range(0, 3))
         0: return POS_MIN;
         1: return POS_MAX;
         2: return '0;
         default: return '1;
      endcase
   endfunction

   function automatic logic [POS_W-1:0] rand_half();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50)
         return POS_W'($urandom_range(200, 4000));
      if (r < 75)
         return POS_W'($urandom());
      return HALF_MAX;
   endfunction

   // response side: random stalls, hold ready between them
   initial begin
      int unsigned stall;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = pick_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   task automatic send_item(input req_code_type kind, input int idx,
                            input logic signed [POS_W-1:0] px,
                            input logic signed [POS_W-1:0] py,
                            input logic signed [POS_W-1:0] pz);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= kind;
      req_atom_index <= IDX_W'(idx);
      req_pos_x      <= px;
      req_pos_y      <= py;
      req_pos_z      <= pz;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      item_total++;
   endtask

   task automatic load_atom(input int slot, input logic signed [POS_W-1:0] px,
                            input logic signed [POS_W-1:0] py,
                            input logic signed [POS_W-1:0] pz);
      gx[slot] = px;
      gy[slot] = py;
      gz[slot] = pz;
      loaded[slot] = 1'b1;
      send_item(REQ_LOAD, slot, px, py, pz);
   endtask

   task automatic load_random(input int slot);
      int src;
      src = $urandom_range(0, ATOM_SLOTS - 1);
      if (loaded[src] && $urandom_range(0, 99) < 30)
         load_atom(slot, gx[src], gy[src], gz[src]);
      else
         load_atom(slot, rand_coord(), rand_coord(), rand_coord());
   endtask

   task automatic scan_row(input int row);
      send_item(REQ_SCAN, row, POS_W'($urandom()), POS_W'($urandom()), POS_W'($urandom()));
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (ledger.pending() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic configure(input logic [CNT_W-1:0] count, input logic [POS_W-1:0] hx,
                            input logic [POS_W-1:0] hy, input logic [POS_W-1:0] hz,
                            input logic [CUT_W-1:0] cut, input bit poke_unused);
      csr_reg_type           regs [5];
      logic [CSR_DATA_W-1:0] vals [5];
      int                    k;
      regs = '{CSR_ATOM_COUNT, CSR_HALF_BOX_X, CSR_HALF_BOX_Y, CSR_HALF_BOX_Z,
               CSR_CUTOFF_LIMIT};
      vals = '{CSR_DATA_W'(count), CSR_DATA_W'(hx), CSR_DATA_W'(hy), CSR_DATA_W'(hz),
               CSR_DATA_W'(cut)};
      settle();
      for (k = 0; k < 5; k++) begin
         csr_we    <= 1'b1;
         csr_index <= regs[k];
         csr_wdata <= vals[k];
         ledger.write_reg(regs[k], vals[k]);
         @(posedge clock);
      end
      if (poke_unused) begin
         csr_index <= CSR_UNUSED;
         csr_wdata <= CSR_DATA_W'({$urandom(), $urandom()});
         @(posedge clock);
      end
      csr_we <= 1'b0;
      active_n = (count > ATOM_SLOTS) ? ATOM_SLOTS : int'(count);
      setting_total++;
   endtask

   task automatic run_traffic(input int count);
      int done;
      int pick;
      int span;
      int k;
      done = 0;
      while (done < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 15) begin
            load_random($urandom_range(0, ATOM_SLOTS - 1));
            done++;
         end else if (pick < 30) begin
            scan_row($urandom_range(0, ATOM_SLOTS - 1));
            done++;
         end else begin
            // ordered pass: row 0 first, then ascending rows
            span = $urandom_range(1, 12);
            if (active_n > 0 && span > active_n)
               span = active_n;
            for (k = 0; k < span; k++)
               scan_row(k);
            done += span;
         end
      end
   endtask

   initial begin
      int                 start_total;
      int                 s;
      int unsigned        pick;
      logic [CNT_W-1:0]   cnt;
      logic [CUT_W-1:0]   cut;
      ledger = new();
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_type       <= REQ_LOAD;
      req_atom_index <= '0;
      req_pos_x      <= '0;
      req_pos_y      <= '0;
      req_pos_z      <= '0;
      csr_we         <= 1'b0;
      csr_index      <= CSR_ATOM_COUNT;
      csr_wdata      <= '0;
      quiet          = 1'b0;
      item_total     = 0;
      setting_total  = 0;
      active_n       = ATOM_SLOTS;
      for (s = 0; s < ATOM_SLOTS; s++)
         loaded[s] = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // boundary cases: difference equal to the half box, distance equal to the cutoff
      configure(7'd6, 20'd256, HALF_MAX, HALF_MAX, 44'd65536, 1'b0);
      load_atom(0, '0, '0, '0);
      load_atom(1, 20'sd256, '0, '0);
      load_atom(2, 20'sd257, '0, '0);
      load_atom(3, '0, 20'sd255, '0);
      load_atom(4, '0, '0, -20'sd256);
      load_atom(5, '0, '0, -20'sd257);
      scan_row(0);
      scan_row(1);
      scan_row(5);
      scan_row(6);
      scan_row(63);

      // full-range coordinates against the widest box and cutoff
      configure(7'd6, HALF_MAX, HALF_MAX, HALF_MAX, CUT_MAX, 1'b0);
      load_atom(2, POS_MAX, POS_MAX, POS_MAX);
      load_atom(3, POS_MIN, POS_MIN, POS_MIN);
      load_atom(4, '1, '1, '1);
      scan_row(0);
      scan_row(2);

      configure(7'd0, HALF_MAX, HALF_MAX, HALF_MAX, CUT_MAX, 1'b0);
      scan_row(0);
      scan_row(3);

      // zero box and zero cutoff: only coincident atoms pair
      configure(7'd2, '0, '0, '0, '0, 1'b0);
      load_atom(1, '0, '0, '0);
      scan_row(0);
      load_atom(1, 20'sd1, '0, '0);
      scan_row(0);

      start_total = item_total;
      configure(7'd64, HALF_MAX, HALF_MAX, HALF_MAX, CUTOFF_RESET, 1'b0);
      for (s = ATOM_SLOTS - 1; s >= 0; s--) begin
         load_random(s);
         if ($urandom_range(0, 99) < 35)
            scan_row($urandom_range(s, ATOM_SLOTS - 1));
      end

      configure(7'd127, HALF_MAX, HALF_MAX, HALF_MAX, CUT_MAX, 1'b0);
      run_traffic(20);
      quiet = 1'b1;
      configure(7'd16, 20'd768, 20'd1024, 20'd512, 44'd1048576, 1'b0);
      run_traffic(20);
      quiet = 1'b0;
      configure(7'd64, '0, '0, '0, '0, 1'b1);
      run_traffic(15);

      while (item_total - start_total < RANDOM_ITEMS) begin
         if ($urandom_range(0, 99) < 20)
            cnt = CNT_W'($urandom_range(65, 127));
         else
            cnt = CNT_W'($urandom_range(0, 64));
         pick = $urandom_range(0, 99);
         if (pick < 60)
            cut = CUT_W'($urandom_range(0, 4194304));
         else if (pick < 80)
            cut = CUT_W'({$urandom(), $urandom()});
         else
            cut = CUT_MAX;
         configure(cnt, rand_half(), rand_half(), rand_half(), cut, 1'b0);
         run_traffic(20);
      end

      settle();
      repeat (64) @(posedge clock);
      $display("Run covered %0d transactions over %0d register settings", item_total,
               setting_total);
      $display("Checked %0d responses including %0d pairs, %0d mismatches",
               ledger.results_seen, ledger.pairs_seen, ledger.mismatch_count);
      if (ledger.mismatch_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
